// ===== hw/rtl/rrq_pkg.sv =====
// Shared types and constants for the round-robin run queue.
// Holds payload structs, request and status codes and controller states.
// No dependencies.
package rrq_pkg;

  localparam int unsigned CAP_W       = 5;
  localparam int unsigned PID_FIELD_W = 16;
  localparam int unsigned TOTAL_W     = 5;

  typedef logic [CAP_W-1:0]       cap_t;
  typedef logic [PID_FIELD_W-1:0] pid_field_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  localparam cap_t CAP_RESET = cap_t'(16);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_ROTATE = 2'd2,
    REQ_LOOKUP = 2'd3
  } rrq_req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } rrq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_ROT_RD,
    S_ROT_WR,
    S_HEAD_RD,
    S_RESP
  } rrq_state_e;

  typedef struct packed {
    logic [1:0] req_type;
    pid_field_t proc_id;
  } rrq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       head_valid;
    pid_field_t head_pid;
    total_t     entry_total;
  } rrq_out_t;

endpackage

// ===== hw/rtl/rrq_mem.sv =====
// Ring storage for the run queue: one write port, one read port,
// read data registered. No package dependency.
module rrq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rrq_ctrl.sv =====
// Run queue sequencer: decodes requests, walks the ring through the
// storage ports, keeps head and count, and holds the result register.
// Depends on rrq_pkg.
module rrq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PID_WIDTH   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rrq_pkg::rrq_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rrq_pkg::rrq_out_t                out_data_o,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] cap_i,
  output logic                             mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_waddr_o,
  output logic [PID_WIDTH-1:0]             mem_wdata_o,
  output logic                             mem_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_raddr_o,
  input  logic [PID_WIDTH-1:0]             mem_rdata_i
);

  import rrq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CW-1:0] cnt_t;
  typedef logic [IW-1:0] idx_t;

  // head + offset, wrapped; the sum stays below twice the depth
  function automatic idx_t ring_idx(input idx_t base, input cnt_t off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return idx_t'(sum);
  endfunction

  rrq_state_e  state_q, state_d;
  idx_t        head_q, head_d;
  cnt_t        count_q, count_d;
  cnt_t        walk_q, walk_d;
  cnt_t        tag_q, tag_d;
  logic        tag_v_q, tag_v_d;
  rrq_req_e    req_q, req_d;
  logic [PID_WIDTH-1:0] pid_q, pid_d;
  rrq_status_e status_q, status_d;
  logic        out_valid_q, out_valid_d;
  rrq_out_t    out_q, out_d;

  logic [PID_WIDTH-1:0] pid_in;
  rrq_req_e             req_in;
  cnt_t                 walk_off;
  cnt_t                 tag_off;
  logic                 hit;

  assign pid_in = PID_WIDTH'(in_data_i.proc_id);
  assign req_in = rrq_req_e'(in_data_i.req_type);

  // search order: head, tail, then the middle from the head onward
  always_comb begin
    if (walk_q == '0) begin
      walk_off = '0;
    end else if (walk_q == cnt_t'(1)) begin
      walk_off = count_q - cnt_t'(1);
    end else begin
      walk_off = walk_q - cnt_t'(1);
    end
    if (tag_q == '0) begin
      tag_off = '0;
    end else if (tag_q == cnt_t'(1)) begin
      tag_off = count_q - cnt_t'(1);
    end else begin
      tag_off = tag_q - cnt_t'(1);
    end
  end

  assign hit = (mem_rdata_i == pid_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    walk_d      = walk_q;
    tag_d       = tag_q;
    tag_v_d     = tag_v_q;
    req_d       = req_q;
    pid_d       = pid_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = head_q;
    mem_wdata_o = pid_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = req_in;
          pid_d    = pid_in;
          status_d = STAT_OK;
          walk_d   = '0;
          tag_v_d  = 1'b0;
          case (req_in)
            REQ_ADD: begin
              state_d = S_HEAD_RD;
              if (count_q < cap_i) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = ring_idx(head_q, count_q);
                mem_wdata_o = pid_in;
                count_d     = count_q + cnt_t'(1);
              end else begin
                status_d = STAT_FULL;
              end
            end
            REQ_ROTATE: begin
              state_d = (count_q >= cnt_t'(2)) ? S_ROT_RD : S_HEAD_RD;
            end
            REQ_REMOVE, REQ_LOOKUP: begin
              if (count_q == '0) begin
                status_d = STAT_NOT_FOUND;
                state_d  = S_HEAD_RD;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_HEAD_RD;
            end
          endcase
        end
      end

      // reads are issued one per cycle; compare runs one entry behind
      S_SCAN: begin
        if (walk_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ring_idx(head_q, walk_off);
          walk_d      = walk_q + cnt_t'(1);
          tag_d       = walk_q;
          tag_v_d     = 1'b1;
        end else begin
          tag_v_d = 1'b0;
        end
        if (tag_v_q) begin
          if (hit) begin
            if (req_q == REQ_LOOKUP) begin
              state_d = S_HEAD_RD;
            end else if (tag_off == '0) begin
              head_d  = (count_q == cnt_t'(1)) ? '0 : ring_idx(head_q, cnt_t'(1));
              count_d = count_q - cnt_t'(1);
              state_d = S_HEAD_RD;
            end else begin
              walk_d  = tag_off + cnt_t'(1);
              tag_v_d = 1'b0;
              state_d = S_SHIFT;
            end
          end else if (tag_q == count_q - cnt_t'(1)) begin
            status_d = STAT_NOT_FOUND;
            state_d  = S_HEAD_RD;
          end
        end
      end

      // close the gap: entry at offset k+1 moves to offset k
      S_SHIFT: begin
        if (tag_v_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ring_idx(head_q, tag_q - cnt_t'(1));
          mem_wdata_o = mem_rdata_i;
        end
        if (walk_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ring_idx(head_q, walk_q);
          walk_d      = walk_q + cnt_t'(1);
          tag_d       = walk_q;
          tag_v_d     = 1'b1;
        end else begin
          tag_v_d = 1'b0;
          count_d = count_q - cnt_t'(1);
          state_d = S_HEAD_RD;
        end
      end

      S_ROT_RD: begin
        mem_re_o = 1'b1;
        state_d  = S_ROT_WR;
      end

      S_ROT_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ring_idx(head_q, count_q);
        mem_wdata_o = mem_rdata_i;
        head_d      = ring_idx(head_q, cnt_t'(1));
        state_d     = S_HEAD_RD;
      end

      S_HEAD_RD: begin
        mem_re_o = 1'b1;
        state_d  = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_d.status            = status_q;
          out_d.head_valid        = (count_q != '0);
          out_d.head_pid          = (count_q != '0) ? pid_field_t'(mem_rdata_i) : '0;
          out_d.entry_total       = total_t'(count_q);
          state_d                 = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      tag_q       <= '0;
      tag_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      tag_q       <= tag_d;
      tag_v_q     <= tag_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    pid_q    <= pid_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write to the same slot in one cycle");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0))
    else $error("empty queue with nonzero head slot");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result loaded outside the response step");
`endif

endmodule

// ===== hw/rtl/round_robin_run_queue.sv =====
// Top level of the round-robin run queue: capacity register, clamp,
// sequencer and ring storage. Depends on rrq_pkg, rrq_ctrl and rrq_mem.
//
//  channel  direction  handshake                 payload
//  in       in         in_valid_i / in_ready_o   in_data_i   (rrq_in_t)
//  out      out        out_valid_o / out_ready_i out_data_o  (rrq_out_t)
//  cfg      in         cfg_valid_i / cfg_ready_o cfg_data_i  (capacity limit)
//
// One request at a time. Every request ends with a read of the head slot for the
// result; rotate with two or more entries first copies the head to the tail. A
// search reads one slot per cycle through the single read port; a remove from
// the middle or tail then shifts the rest down.
// The next request is taken while the previous result waits on out.
// Reset empties the queue and sets the capacity to 16; storage is not cleared.
module round_robin_run_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PID_WIDTH   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrq_pkg::rrq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrq_pkg::rrq_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  rrq_pkg::cap_t     cfg_data_i
);

  import rrq_pkg::*;

  localparam int unsigned IW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CW > CAP_W) ? CW : CAP_W;

  cap_t             cap_q;
  logic [CMP_W-1:0] cap_wide;
  logic [CW-1:0]    cap_eff;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [PID_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  logic [PID_WIDTH-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // a limit above the ring size acts as the ring size
  assign cap_wide = CMP_W'(cap_q);
  assign cap_eff  = (cap_wide > CMP_W'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(cap_wide);

  rrq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_WIDTH   (PID_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cap_i       (cap_eff),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  rrq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (PID_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the round-robin run queue (round_robin_run_queue).
// Predicts every result with an ordered pid list and checks the out channel field by field.
// Depends on rrq_pkg and the RTL of the block.
module tb;
  import rrq_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int CYCLE_CAP  = 1000000;
  localparam int RAND_ITEMS = 100;
  localparam int RAND_PHASE = 14;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  rrq_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rrq_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cap_t       cfg_data = '0;

  // predictor state
  pid_field_t ring_model[$];
  cap_t       cap_limit = CAP_RESET;
  rrq_out_t   pending_results[$];

  int         errors = 0;
  int         cycles = 0;
  int         burst_left = 0;
  int         n_items = 0;
  int         n_checked = 0;
  int         n_full = 0;
  int         n_missing = 0;
  logic [8:0] stall_tick = '0;

  round_robin_run_queue uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: four stall modes, taken in turn
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 9'd1;
    case (stall_tick[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(3) != 0);
      2'd2: out_ready <= (stall_tick[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(1) == 1);
    endcase
  end

  // search order: head, then tail, then from the head onward
  function automatic int match_pos(pid_field_t pid);
    int n;
    n = ring_model.size();
    if (n == 0) return -1;
    if (ring_model[0] == pid) return 0;
    if (ring_model[n-1] == pid) return n - 1;
    for (int i = 1; i < n - 1; i++) begin
      if (ring_model[i] == pid) return i;
    end
    return -1;
  endfunction

  task automatic apply_request(rrq_in_t req);
    rrq_out_t res;
    int       pos;
    int       lim;
    lim = (int'(cap_limit) > QDEPTH) ? QDEPTH : int'(cap_limit);
    res = '0;
    res.status = STAT_OK;
    case (rrq_req_e'(req.req_type))
      REQ_ADD: begin
        if (ring_model.size() < lim) ring_model.push_back(req.proc_id);
        else res.status = STAT_FULL;
      end
      REQ_REMOVE: begin
        pos = match_pos(req.proc_id);
        if (pos < 0) res.status = STAT_NOT_FOUND;
        else ring_model.delete(pos);
      end
      REQ_ROTATE: begin
        if (ring_model.size() >= 2) ring_model.push_back(ring_model.pop_front());
      end
      default: begin
        pos = match_pos(req.proc_id);
        if (pos < 0) res.status = STAT_NOT_FOUND;
      end
    endcase
    if (res.status == STAT_FULL) n_full++;
    if (res.status == STAT_NOT_FOUND) n_missing++;
    res.head_valid  = (ring_model.size() > 0);
    res.head_pid    = (ring_model.size() > 0) ? ring_model[0] : '0;
    res.entry_total = total_t'(ring_model.size());
    pending_results.push_back(res);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    rrq_out_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        check_field("status", exp_r.status, out_data.status);
        check_field("head_valid", exp_r.head_valid, out_data.head_valid);
        check_field("head_pid", exp_r.head_pid, out_data.head_pid);
        check_field("entry_total", exp_r.entry_total, out_data.entry_total);
      end
    end
  end

  // one request transfer; valid stays high across a burst
  task automatic send_req(rrq_req_e op, pid_field_t pid);
    rrq_in_t req;
    int      gap;
    req.req_type = op;
    req.proc_id  = pid;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    apply_request(req);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(cap_t value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cap_limit = value;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_basic_ops;
    send_req(REQ_LOOKUP, 16'h1234);   // empty queue
    send_req(REQ_REMOVE, 16'h1234);
    send_req(REQ_ROTATE, 16'h0000);
    send_req(REQ_ADD, 16'h0000);
    send_req(REQ_ROTATE, 16'hFFFF);   // single entry, no change
    send_req(REQ_LOOKUP, 16'h0000);
    send_req(REQ_ADD, 16'hFFFF);
    send_req(REQ_ADD, 16'h0000);      // duplicate
    send_req(REQ_ADD, 16'hA5A5);
    send_req(REQ_ADD, 16'h5A5A);
    send_req(REQ_ADD, 16'h0000);
    send_req(REQ_ROTATE, 16'h0000);
    send_req(REQ_REMOVE, 16'h0000);   // tail match wins over middle
    send_req(REQ_REMOVE, 16'h0000);   // tail match again
    send_req(REQ_LOOKUP, 16'h5A5A);
    send_req(REQ_LOOKUP, 16'h0001);
    send_req(REQ_REMOVE, 16'hFFFF);
    send_req(REQ_REMOVE, 16'h1111);
    send_req(REQ_ROTATE, 16'h0000);
    send_req(REQ_REMOVE, 16'hA5A5);
    send_req(REQ_REMOVE, 16'h5A5A);
    send_req(REQ_LOOKUP, 16'h5A5A);
    drain();
  endtask

  task automatic test_capacity;
    set_capacity(cap_t'(0));
    send_req(REQ_ADD, 16'h0001);      // zero capacity: full
    send_req(REQ_LOOKUP, 16'h0001);
    drain();
    set_capacity(cap_t'(31));         // above depth, acts as full depth
    for (int i = 0; i < QDEPTH + 1; i++) send_req(REQ_ADD, pid_field_t'(16'h8000 + i));
    send_req(REQ_ROTATE, 16'h0000);
    send_req(REQ_LOOKUP, 16'h800F);
    drain();
    set_capacity(cap_t'(2));          // lowered below the count
    send_req(REQ_ADD, 16'h7777);
    while (ring_model.size() > 1) send_req(REQ_REMOVE, ring_model[ring_model.size() / 2]);
    send_req(REQ_ADD, 16'h7777);
    send_req(REQ_ADD, 16'h6666);
    drain();
  endtask

  task automatic test_random_traffic;
    int         pick;
    rrq_req_e   op;
    pid_field_t pid;
    for (int ph = 0; ph < RAND_PHASE; ph++) begin
      case (ph)
        0: set_capacity(cap_t'(16));
        1: set_capacity(cap_t'(1));
        2: set_capacity(cap_t'(31));
        3: set_capacity(cap_t'(0));
        4: set_capacity(cap_t'(17));
        5: set_capacity(cap_t'(2));
        default: set_capacity(cap_t'($urandom_range(0, 31)));
      endcase
      for (int k = 0; k < RAND_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 40) op = REQ_ADD;
        else if (pick < 65) op = REQ_REMOVE;
        else if (pick < 78) op = REQ_ROTATE;
        else op = REQ_LOOKUP;
        pick = $urandom_range(99);
        if (pick < 50 && ring_model.size() > 0)
          pid = ring_model[$urandom_range(ring_model.size() - 1)];
        else if (pick < 80)
          pid = pid_field_t'($urandom_range(7));
        else
          pid = pid_field_t'($urandom_range(16'hFFFF));
        send_req(op, pid);
      end
      drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_capacity();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results over %0d cycles", n_items, n_checked,
             cycles);
    $display("Capacity settings 0 to 31 seen; %0d full and %0d not-found responses", n_full,
             n_missing);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== round_robin_run_queue.f =====
hw/rtl/rrq_pkg.sv
hw/rtl/rrq_mem.sv
hw/rtl/rrq_ctrl.sv
hw/rtl/round_robin_run_queue.sv
sim/tb.sv
